@@ rtl/pngu_pkg.sv @@
// ============================================================================
// pngu_pkg: shared types and codes for the PNG scanline unfilter
// Filter type codes, configuration register indexes and the neighbor bundle
// passed to the predictor.
// ============================================================================
`default_nettype none

package pngu_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] filt_t;

  localparam filt_t FILT_NONE  = 3'd0;
  localparam filt_t FILT_SUB   = 3'd1;
  localparam filt_t FILT_UP    = 3'd2;
  localparam filt_t FILT_AVG   = 3'd3;
  localparam filt_t FILT_PAETH = 3'd4;

  localparam int unsigned CfgAw = 1;
  localparam int unsigned CfgDw = 13;

  localparam logic [CfgAw-1:0] CFG_IMAGE_WIDTH = 1'b0;
  localparam logic [CfgAw-1:0] CFG_CHANNELS    = 1'b1;

  // left, above and above-left neighbors of the current channel byte
  typedef struct packed {
    byte_t a;
    byte_t b;
    byte_t c;
  } pngu_nbr_t;

endpackage

`default_nettype wire

@@ rtl/pngu_predict.sv @@
// ============================================================================
// pngu_predict: PNG filter predictor
// Selects the None, Sub, Up, Average or Paeth predictor from the three
// neighbor bytes.
// ============================================================================
`default_nettype none

module pngu_predict
  import pngu_pkg::*;
(
  input  filt_t     filt_i,
  input  pngu_nbr_t nbr_i,
  output byte_t     pred_o
);

  logic signed [9:0] d_bc;
  logic signed [9:0] d_ac;
  logic signed [9:0] d_sum;
  logic        [9:0] dist_a;
  logic        [9:0] dist_b;
  logic        [9:0] dist_c;
  logic        [8:0] avg_sum;
  byte_t             paeth;

  function automatic logic [9:0] abs10(input logic signed [9:0] v);
    abs10 = v[9] ? 10'(-v) : 10'(v);
  endfunction

  assign d_bc    = $signed({2'b00, nbr_i.b}) - $signed({2'b00, nbr_i.c});
  assign d_ac    = $signed({2'b00, nbr_i.a}) - $signed({2'b00, nbr_i.c});
  assign d_sum   = d_bc + d_ac;
  assign dist_a  = abs10(d_bc);
  assign dist_b  = abs10(d_ac);
  assign dist_c  = abs10(d_sum);
  assign avg_sum = {1'b0, nbr_i.a} + {1'b0, nbr_i.b};

  always_comb begin
    if ((dist_a <= dist_b) && (dist_a <= dist_c)) begin
      paeth = nbr_i.a;
    end else if (dist_b <= dist_c) begin
      paeth = nbr_i.b;
    end else begin
      paeth = nbr_i.c;
    end
  end

  always_comb begin
    case (filt_i)
      FILT_SUB:   pred_o = nbr_i.a;
      FILT_UP:    pred_o = nbr_i.b;
      FILT_AVG:   pred_o = avg_sum[8:1];
      FILT_PAETH: pred_o = paeth;
      default:    pred_o = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/png_scanline_unfilter_core.sv @@
// ============================================================================
// png_scanline_unfilter_core: PNG scanline filter reconstruction
// Rebuilds channel bytes of an inflated PNG stream from their row filter.
// ============================================================================
// One byte is taken per clock while the result stage is not stalled: an input
// register, one pass of predictor logic and a result register, so a byte can
// enter every cycle unless a result waits on m_axis_tready. The row above
// lives in a one-read, one-write line store of MAX_WIDTH*MAX_CHANNELS bytes;
// its address for the next byte is read ahead from the next counter state, and
// a bypass covers a read of the entry being written. The first byte of each
// row is the filter type and gives no result. The store needs no clearing
// after reset: the first row of an image never reads it.
`default_nettype none

module png_scanline_unfilter_core
  import pngu_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 4096,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  wire              clk_i,
  input  wire              rst_ni,

  input  wire              cfg_we_i,
  input  wire  [CfgAw-1:0] cfg_addr_i,
  input  wire  [CfgDw-1:0] cfg_wdata_i,

  input  wire              s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire  [7:0]       s_axis_tdata,   // [7:0] data_byte
  input  wire  [0:0]       s_axis_tuser,   // [0] image_start

  output logic             m_axis_tvalid,
  input  wire              m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] pixel_byte, [9:8] channel_index
  output logic             m_axis_tlast    // end_of_row
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW    = CW + 1;

  function automatic logic [2:0] eff_ch(input logic [2:0] v);
    if (v == 3'd0) begin
      eff_ch = 3'd1;
    end else if (32'(v) > MAX_CHANNELS) begin
      eff_ch = 3'(MAX_CHANNELS);
    end else begin
      eff_ch = v;
    end
  endfunction

  // configuration
  logic [CfgDw-1:0] width_q, width_d;
  logic [2:0]       chans_q, chans_d;
  logic [WW-1:0]    w_eff;
  logic [2:0]       nch;
  logic [2:0]       nch_nx;

  // input stage
  logic             v1_q, v1_d;
  byte_t            dat1_q;
  logic             start1_q;

  // row state
  logic [CW-1:0]    col_q, col_d;
  logic [1:0]       ch_q, ch_d;
  byte_t [3:0]      left_q, left_d;
  byte_t [3:0]      upl_q, upl_d;
  filt_t            filt_q, filt_d;
  logic             first_q, first_d;
  logic             rstart_q, rstart_d;

  // line store
  byte_t            mem [Depth];
  byte_t            rd_q;
  logic [AW-1:0]    cur_idx_q;
  logic [AW-1:0]    raddr;
  logic [31:0]      nxt_full;
  logic             byp_q;
  byte_t            byp_dat_q;

  // result stage
  logic             ov_q, ov_d;
  byte_t            pix_q;
  logic [1:0]       chi_q;
  logic             eor_q;

  logic             out_rdy;
  logic             fire;
  logic             acc;
  logic             emit;
  logic             eor;
  pngu_nbr_t        nbr;
  byte_t            pred;
  byte_t            res;

  assign out_rdy       = !ov_q || m_axis_tready;
  assign fire          = v1_q && out_rdy;
  assign s_axis_tready = !v1_q || out_rdy;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign v1_d          = acc ? 1'b1 : (fire ? 1'b0 : v1_q);

  always_comb begin
    width_d = width_q;
    chans_d = chans_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_IMAGE_WIDTH: width_d = cfg_wdata_i;
        CFG_CHANNELS:    chans_d = cfg_wdata_i[2:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
  end

  assign nch    = eff_ch(chans_q);
  assign nch_nx = eff_ch(chans_d);

  always_comb begin
    nbr.a = (col_q != '0) ? left_q[ch_q] : '0;
    nbr.b = first_q ? '0 : (byp_q ? byp_dat_q : rd_q);
    nbr.c = ((col_q != '0) && !first_q) ? upl_q[ch_q] : '0;
  end

  pngu_predict u_predict (
    .filt_i (filt_q),
    .nbr_i  (nbr),
    .pred_o (pred)
  );

  assign res = dat1_q + pred;

  always_comb begin
    col_d    = col_q;
    ch_d     = ch_q;
    left_d   = left_q;
    upl_d    = upl_q;
    filt_d   = filt_q;
    first_d  = first_q;
    rstart_d = rstart_q;
    emit     = 1'b0;
    eor      = 1'b0;
    if (fire) begin
      if (rstart_q || start1_q) begin
        if (start1_q) begin
          col_d   = '0;
          ch_d    = '0;
          left_d  = '0;
          upl_d   = '0;
          first_d = 1'b1;
        end
        filt_d   = (dat1_q > byte_t'(FILT_PAETH)) ? FILT_NONE : dat1_q[2:0];
        rstart_d = 1'b0;
      end else begin
        emit         = 1'b1;
        left_d[ch_q] = res;
        upl_d[ch_q]  = nbr.b;
        if (({1'b0, ch_q} + 3'd1) >= nch) begin
          ch_d = '0;
          if ((WW'(col_q) + WW'(1)) >= w_eff) begin
            eor      = 1'b1;
            col_d    = '0;
            left_d   = '0;
            upl_d    = '0;
            rstart_d = 1'b1;
            first_d  = 1'b0;
          end else begin
            col_d = col_q + CW'(1);
          end
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
    end
  end

  // address of the byte that follows, registered through rd_q ahead of its use
  assign nxt_full = 32'(col_d) * 32'(nch_nx) + 32'(ch_d);
  assign raddr    = nxt_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (emit) begin
      mem[cur_idx_q] <= res;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    byp_dat_q <= res;
    dat1_q    <= acc ? s_axis_tdata : dat1_q;
    start1_q  <= acc ? s_axis_tuser[0] : start1_q;
    if (emit) begin
      pix_q <= res;
      chi_q <= ch_q;
      eor_q <= eor;
    end
  end

  assign ov_d = emit ? 1'b1 : (m_axis_tready ? 1'b0 : ov_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= CfgDw'(1);
      chans_q   <= 3'd3;
      v1_q      <= 1'b0;
      col_q     <= '0;
      ch_q      <= '0;
      left_q    <= '0;
      upl_q     <= '0;
      filt_q    <= FILT_NONE;
      first_q   <= 1'b1;
      rstart_q  <= 1'b1;
      cur_idx_q <= '0;
      byp_q     <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      width_q   <= width_d;
      chans_q   <= chans_d;
      v1_q      <= v1_d;
      col_q     <= col_d;
      ch_q      <= ch_d;
      left_q    <= left_d;
      upl_q     <= upl_d;
      filt_q    <= filt_d;
      first_q   <= first_d;
      rstart_q  <= rstart_d;
      cur_idx_q <= raddr;
      byp_q     <= emit && (cur_idx_q == raddr);
      ov_q      <= ov_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'b000000, chi_q, pix_q};
  assign m_axis_tlast  = eor_q;

endmodule

`default_nettype wire

@@ rtl/pngu_checker.sv @@
// ============================================================================
// pngu_checker: port-level checks for the PNG scanline unfilter
// Watches the stream ports of the core over time; bound to the top level.
// ============================================================================
`default_nettype none

module pngu_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [15:0] m_axis_tdata,
  input wire        m_axis_tlast
);

  logic after_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_last_q <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      after_last_q <= m_axis_tlast;
    end
  end

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // no result beat is offered during reset
  a_rst_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result beat offered in reset");

  // a new result beat rises after its byte was taken and passed the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result beat without a matching input beat");

  // a row starts at channel zero
  a_row_ch0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && after_last_q |-> m_axis_tdata[9:8] == 2'd0)
    else $error("row does not start at channel zero");

endmodule

bind png_scanline_unfilter_core pngu_checker u_pngu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ test/png_scanline_unfilter_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// png_scanline_unfilter_core_tb: self-checking bench for the scanline unfilter
// Streams filter-type and channel bytes through the core under several image
// geometries, including clamped register values, and compares every pixel
// beat with a cycle-free software reconstruction of the PNG row filters.
// ============================================================================

module png_scanline_unfilter_core_tb;
  import pngu_pkg::*;

  localparam int unsigned MaxW       = 4096;
  localparam int unsigned MaxCh      = 4;
  localparam int unsigned StoreDepth = MaxW * MaxCh;

  typedef struct packed {
    byte_t      pix;
    logic [1:0] chan;
    logic       eor;
  } pixel_beat_t;

  // Row reconstruction: tracks the filter state and the expected pixel beats.
  class unfilter_tracker;
    byte_t         line_store [0:StoreDepth-1];
    logic [12:0]   width_reg = 13'd1;
    logic [2:0]    chan_reg  = 3'd3;
    logic [31:0]   left_px   = '0;
    logic [31:0]   upleft_px = '0;
    int unsigned   col_cnt   = 0;
    int unsigned   chan_cnt  = 0;
    filt_t         row_filter = FILT_NONE;
    bit            first_row = 1'b1;
    bit            at_row_start = 1'b1;
    pixel_beat_t   pending [$];
    int unsigned   n_in = 0;
    int unsigned   n_out = 0;
    int unsigned   n_rows = 0;
    int unsigned   n_errors = 0;

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MaxW) return MaxW;
      return width_reg;
    endfunction

    function int unsigned eff_chans();
      if (chan_reg == 0) return 1;
      if (chan_reg > MaxCh) return MaxCh;
      return chan_reg;
    endfunction

    function void set_reg(logic [CfgAw-1:0] idx, logic [CfgDw-1:0] val);
      if (idx == CFG_IMAGE_WIDTH) width_reg = val;
      else if (idx == CFG_CHANNELS) chan_reg = val[2:0];
    endfunction

    function void restart_row();
      col_cnt = 0;
      chan_cnt = 0;
      left_px = '0;
      upleft_px = '0;
      at_row_start = 1'b1;
    endfunction

    function byte_t paeth_pick(byte_t a, byte_t b, byte_t c);
      int p, pa, pb, pc;
      p  = int'(a) + int'(b) - int'(c);
      pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
      pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
      pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
    endfunction

    function void take_byte(byte_t d, bit img_start);
      int unsigned w, nch, ch, col, idx;
      byte_t       a, b, c, pred, r;
      bit          row_end;
      n_in++;
      w = eff_width();
      nch = eff_chans();
      if (img_start) begin
        restart_row();
        first_row = 1'b1;
      end
      if (at_row_start) begin
        row_filter = (d > 8'(FILT_PAETH)) ? FILT_NONE : filt_t'(d[2:0]);
        at_row_start = 1'b0;
        return;
      end
      ch = chan_cnt;
      col = col_cnt;
      idx = col * nch + ch;
      a = (col != 0) ? left_px[ch*8 +: 8] : 8'd0;
      b = (!first_row && idx < StoreDepth) ? line_store[idx] : 8'd0;
      c = (col != 0 && !first_row) ? upleft_px[ch*8 +: 8] : 8'd0;
      case (row_filter)
        FILT_SUB:   pred = a;
        FILT_UP:    pred = b;
        FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
        FILT_PAETH: pred = paeth_pick(a, b, c);
        default:    pred = 8'd0;
      endcase
      r = d + pred;
      if (idx < StoreDepth) line_store[idx] = r;
      left_px[ch*8 +: 8] = r;
      upleft_px[ch*8 +: 8] = b;
      row_end = 1'b0;
      if (ch + 1 >= nch) begin
        chan_cnt = 0;
        if (col + 1 >= w) begin
          row_end = 1'b1;
          restart_row();
          first_row = 1'b0;
        end else begin
          col_cnt = col + 1;
        end
      end else begin
        chan_cnt = ch + 1;
      end
      pending.push_back('{pix: r, chan: 2'(ch), eor: row_end});
    endfunction

    function void check_pixel(logic [15:0] tdata, logic tlast);
      pixel_beat_t want;
      if (pending.size() == 0) begin
        $error("pixel beat with nothing expected: tdata %h tlast %b", tdata, tlast);
        n_errors++;
        return;
      end
      want = pending.pop_front();
      n_out++;
      if (tlast === 1'b1) n_rows++;
      if (tdata[7:0] !== want.pix) begin
        $error("pixel_byte: expected %0d, got %0d", want.pix, tdata[7:0]);
        n_errors++;
      end
      if (tdata[9:8] !== want.chan) begin
        $error("channel_index: expected %0d, got %0d", want.chan, tdata[9:8]);
        n_errors++;
      end
      if (tlast !== want.eor) begin
        $error("end_of_row: expected %0d, got %0d", want.eor, tlast);
        n_errors++;
      end
      if (tdata[15:10] !== 6'd0) begin
        $error("tdata pad: expected 0, got %0d", tdata[15:10]);
        n_errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CfgAw-1:0] cfg_addr = '0;
  logic [CfgDw-1:0] cfg_wdata = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;
  logic [0:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [15:0]      m_tdata;
  logic             m_tlast;

  unfilter_tracker  tracker = new();
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  int unsigned      n_settings = 0;

  png_scanline_unfilter_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) tracker.check_pixel(m_tdata, m_tlast);
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic byte_t rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_beat(input byte_t d, input bit img_start);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= img_start;
    do @(posedge clk_i); while (!s_tready);
    tracker.take_byte(d, img_start);
  endtask

  // wait for all pixel beats, then for the pipeline to settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(input int unsigned wv, input int unsigned cv);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_IMAGE_WIDTH;
    cfg_wdata <= CfgDw'(wv);
    @(posedge clk_i);
    cfg_addr <= CFG_CHANNELS;
    cfg_wdata <= CfgDw'(cv);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tracker.set_reg(CFG_IMAGE_WIDTH, CfgDw'(wv));
    tracker.set_reg(CFG_CHANNELS, CfgDw'(cv));
    n_settings++;
  endtask

  // Whole images of random rows; a few rows are cut short and the image
  // restarts. The last row may be left open for the next setting to abandon.
  task automatic run_images(input int unsigned wv, input int unsigned cv,
                            input int unsigned budget);
    int unsigned full_len, len, n_img_rows, sent;
    byte_t       filt;
    drain();
    write_regs(wv, cv);
    full_len = tracker.eff_width() * tracker.eff_chans();
    sent = 0;
    while (sent < budget) begin
      n_img_rows = $urandom_range(1, 5);
      for (int row = 0; row < n_img_rows && sent < budget; row++) begin
        filt = ($urandom_range(9) == 0) ? 8'($urandom_range(5, 255))
                                        : 8'($urandom_range(0, 4));
        send_beat(filt, row == 0);
        sent++;
        len = full_len;
        if ($urandom_range(19) == 0) len = $urandom_range(0, full_len - 1);
        for (int k = 0; k < len && sent < budget; k++) begin
          send_beat(rand_byte(), 1'b0);
          sent++;
        end
        if (len < full_len) break;
      end
    end
  endtask

  initial begin
    int unsigned wv, cv;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 30;
    recv_idle_pct = 51;

    // reset geometry: one pixel of three channels per row
    send_beat(8'(FILT_PAETH), 1'b1);
    send_beat(8'd0, 1'b0);
    send_beat(8'd255, 1'b0);
    send_beat(8'd128, 1'b0);
    send_beat(8'(FILT_UP), 1'b0);
    send_beat(8'd255, 1'b0);
    send_beat(8'd1, 1'b0);
    send_beat(8'd128, 1'b0);
    send_beat(8'(FILT_AVG), 1'b0);
    send_beat(8'd200, 1'b0);
    send_beat(8'd100, 1'b0);
    send_beat(8'd255, 1'b0);

    drain();
    write_regs(2, 2);
    send_beat(8'(FILT_SUB), 1'b1);
    send_beat(8'd255, 1'b0);
    send_beat(8'd1, 1'b0);
    send_beat(8'd2, 1'b0);
    send_beat(8'd3, 1'b0);
    send_beat(8'(FILT_PAETH), 1'b0);
    send_beat(8'd9, 1'b0);
    send_beat(8'd8, 1'b0);
    // new image mid-row, unknown filter type
    send_beat(8'h86, 1'b1);
    send_beat(8'd5, 1'b0);
    send_beat(8'd6, 1'b0);
    send_beat(8'd7, 1'b0);

    // narrow the row mid-row: it ends after the current pixel
    drain();
    write_regs(1, 2);
    send_beat(8'd8, 1'b0);
    send_beat(8'(FILT_UP), 1'b0);
    send_beat(8'd250, 1'b0);
    send_beat(8'd4, 1'b0);

    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 5) begin
        send_idle_pct = 51;
        recv_idle_pct = 30;
      end else if (ph == 11) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        2:       begin wv = 0; cv = 4; end   // width clamps to 1
        5:       begin wv = 7; cv = 0; end   // channels clamp to 1
        8:       begin wv = 3; cv = 7; end   // channels clamp to 4
        11:      begin wv = 1; cv = 1; end
        default: begin wv = $urandom_range(1, 12); cv = $urandom_range(1, 4); end
      endcase
      run_images(wv, cv, 74);
    end

    // width above the maximum clamps: the row stays open over these beats
    run_images(13'h1fff, 1, 100);
    drain();

    $display("%0d stream beats in, %0d pixel beats checked, %0d row ends, %0d settings",
             tracker.n_in, tracker.n_out, tracker.n_rows, n_settings);
    $display("widths 1..12 and clamped, 1..4 channels, all filter types, gaps both sides");
    if (tracker.n_errors == 0) begin
      $display("png_scanline_unfilter_core_tb passed");
    end else begin
      $display("png_scanline_unfilter_core_tb failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("png_scanline_unfilter_core_tb failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/pngu_pkg.sv
rtl/pngu_predict.sv
rtl/png_scanline_unfilter_core.sv
rtl/pngu_checker.sv
test/png_scanline_unfilter_core_tb.sv
